>>> rtl/bufu_pkg.sv
`default_nettype none

package bufu_pkg;

  localparam int unsigned TX_FIFO_SIZE = 16;
  localparam int unsigned RX_FIFO_SIZE = 16;
  localparam int unsigned TX_AW = $clog2(TX_FIFO_SIZE);
  localparam int unsigned RX_AW = $clog2(RX_FIFO_SIZE);

  localparam logic [7:0] CHAR_LF = 8'h0A;
  localparam logic [7:0] CHAR_CR = 8'h0D;

  typedef enum logic [2:0] {
    ACT_PUT   = 3'd0,
    ACT_GET   = 3'd1,
    ACT_TXRDY = 3'd2,
    ACT_RECV  = 3'd3,
    ACT_FLUSH = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_TX_FULL  = 2'd1,
    STAT_RX_EMPTY = 2'd2,
    STAT_RX_DROP  = 2'd3
  } status_e;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic [3:0] rx_count;
    logic [3:0] tx_count;
    status_e    status;
    logic       last;
  } result_t;

endpackage

`default_nettype wire

>>> rtl/bufu_ram.sv
`default_nettype none

module bufu_ram #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 8,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> rtl/buffered_uart_fifo_frontend_core.sv
// Transmit and receive byte FIFOs in front of a UART data register.
// Input channel (s_axis): one command per transfer; tuser carries the action
// (put, get, transmitter ready, byte received, flush), tdata the byte and the
// register-empty and receive-error flags. Output channel (m_axis): one result
// per command, two for a line feed put in text mode (carriage return first);
// tlast marks the final result of a command, tuser carries the status.
// cfg_we_i/cfg_data_i set binary mode (no CR insertion); write it while idle.
// Timing: a command is taken while the block is idle, then the result is
// built in the execute state from the registered memory read issued at
// acceptance; a split line feed adds a second result state. The registered
// read port of the FIFO memories is why the result waits for that state.
// The output register decouples the sides: a new command is taken while a
// result still waits. When the receiver stalls, the block holds the pending
// result and waits before loading the next one; the command channel stops
// once the block is busy.
// Reset clears all FIFO pointers and the binary mode bit; stored bytes are
// not cleared, the FIFOs simply read as empty. No clearing pass is needed.
`default_nettype none

module buffered_uart_fifo_frontend_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_data_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [7:0] data_byte, [8] tx_reg_empty, [9] rx_error, [15:10] zero
  input  wire logic [15:0] s_axis_tdata,
  // [2:0] action
  input  wire logic [2:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [0] tx_valid, [8:1] tx_byte, [9] rx_valid, [17:10] rx_byte,
  // [21:18] rx_count, [25:22] tx_count, [31:26] zero
  output logic [31:0]      m_axis_tdata,
  // [1:0] status
  output logic [1:0]       m_axis_tuser,
  output logic             m_axis_tlast
);

  localparam int unsigned TxAw = bufu_pkg::TX_AW;
  localparam int unsigned RxAw = bufu_pkg::RX_AW;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_EXEC  = 2'd1;
  localparam logic [1:0] ST_EMIT2 = 2'd2;

  logic [1:0] state_q, state_d;
  bufu_pkg::action_e act_q;
  logic [7:0] byte_q;
  logic       free_q, free_d;
  logic       err_q;
  logic       binary_q;

  logic [TxAw-1:0] tx_head_q, tx_head_d, tx_tail_q, tx_tail_d, tx_head_inc, tx_tail_inc;
  logic [RxAw-1:0] rx_head_q, rx_head_d, rx_tail_q, rx_tail_d, rx_head_inc, rx_tail_inc;
  logic [TxAw-1:0] tx_lvl;
  logic [RxAw-1:0] rx_lvl;
  logic [7:0]      tx_rdata, rx_rdata, put_byte;

  logic s_accept, out_free, commit, lf_split, do_put, tx_empty, tx_full, rx_empty, rx_full;
  logic tx_we, rx_we;

  bufu_pkg::result_t res, out_q;
  logic out_valid_q;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign commit        = ((state_q == ST_EXEC) || (state_q == ST_EMIT2)) && out_free;

  assign tx_head_inc = (tx_head_q == TxAw'(bufu_pkg::TX_FIFO_SIZE - 1)) ? '0 : tx_head_q + 1'b1;
  assign tx_tail_inc = (tx_tail_q == TxAw'(bufu_pkg::TX_FIFO_SIZE - 1)) ? '0 : tx_tail_q + 1'b1;
  assign rx_head_inc = (rx_head_q == RxAw'(bufu_pkg::RX_FIFO_SIZE - 1)) ? '0 : rx_head_q + 1'b1;
  assign rx_tail_inc = (rx_tail_q == RxAw'(bufu_pkg::RX_FIFO_SIZE - 1)) ? '0 : rx_tail_q + 1'b1;

  assign tx_empty = (tx_head_q == tx_tail_q);
  assign tx_full  = (tx_head_inc == tx_tail_q);
  assign rx_empty = (rx_head_q == rx_tail_q);
  assign rx_full  = (rx_head_inc == rx_tail_q);

  assign lf_split = (act_q == bufu_pkg::ACT_PUT) && !binary_q && (byte_q == bufu_pkg::CHAR_LF);
  assign do_put   = ((state_q == ST_EXEC) && (act_q == bufu_pkg::ACT_PUT)) ||
                    (state_q == ST_EMIT2);
  assign put_byte = (state_q == ST_EMIT2) ? bufu_pkg::CHAR_LF :
                    (lf_split ? bufu_pkg::CHAR_CR : byte_q);

  // Read at the next pop position of both FIFOs when a command is taken.
  bufu_ram #(.DEPTH(bufu_pkg::TX_FIFO_SIZE), .WIDTH(8)) u_tx_ram (
    .clk_i   (clk_i),
    .we_i    (tx_we),
    .waddr_i (tx_head_inc),
    .wdata_i (put_byte),
    .re_i    (s_accept),
    .raddr_i (tx_tail_inc),
    .rdata_o (tx_rdata)
  );

  bufu_ram #(.DEPTH(bufu_pkg::RX_FIFO_SIZE), .WIDTH(8)) u_rx_ram (
    .clk_i   (clk_i),
    .we_i    (rx_we),
    .waddr_i (rx_head_inc),
    .wdata_i (byte_q),
    .re_i    (s_accept),
    .raddr_i (rx_tail_inc),
    .rdata_o (rx_rdata)
  );

  always_comb begin
    tx_head_d = tx_head_q;
    tx_tail_d = tx_tail_q;
    rx_head_d = rx_head_q;
    rx_tail_d = rx_tail_q;
    free_d    = free_q;
    tx_we     = 1'b0;
    rx_we     = 1'b0;
    res       = '0;
    res.status = bufu_pkg::STAT_OK;
    res.last  = !((state_q == ST_EXEC) && lf_split);
    if (do_put) begin
      if (tx_empty && free_q) begin
        res.tx_valid = 1'b1;
        res.tx_byte  = put_byte;
        free_d       = 1'b0;
      end else if (!tx_full) begin
        tx_head_d = tx_head_inc;
        tx_we     = commit;
      end else begin
        res.status = bufu_pkg::STAT_TX_FULL;
      end
    end else begin
      case (act_q)
        bufu_pkg::ACT_GET: begin
          if (rx_empty) begin
            res.status = bufu_pkg::STAT_RX_EMPTY;
          end else begin
            rx_tail_d    = rx_tail_inc;
            res.rx_valid = 1'b1;
            res.rx_byte  = rx_rdata;
          end
        end
        bufu_pkg::ACT_TXRDY: begin
          if (!tx_empty) begin
            tx_tail_d    = tx_tail_inc;
            res.tx_valid = 1'b1;
            res.tx_byte  = tx_rdata;
          end
        end
        bufu_pkg::ACT_RECV: begin
          if (err_q || rx_full) begin
            res.status = bufu_pkg::STAT_RX_DROP;
          end else begin
            rx_head_d = rx_head_inc;
            rx_we     = commit;
          end
        end
        bufu_pkg::ACT_FLUSH: begin
          rx_head_d = '0;
          rx_tail_d = '0;
        end
        default: ;
      endcase
    end
    // Modular levels; the wrap term vanishes for power-of-two sizes.
    tx_lvl = (tx_head_d >= tx_tail_d) ? tx_head_d - tx_tail_d :
             tx_head_d - tx_tail_d + TxAw'(bufu_pkg::TX_FIFO_SIZE);
    rx_lvl = (rx_head_d >= rx_tail_d) ? rx_head_d - rx_tail_d :
             rx_head_d - rx_tail_d + RxAw'(bufu_pkg::RX_FIFO_SIZE);
    res.tx_count = 4'(tx_lvl);
    res.rx_count = 4'(rx_lvl);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (s_accept) state_d = ST_EXEC;
      ST_EXEC:  if (out_free) state_d = lf_split ? ST_EMIT2 : ST_IDLE;
      ST_EMIT2: if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      binary_q    <= 1'b0;
      tx_head_q   <= '0;
      tx_tail_q   <= '0;
      rx_head_q   <= '0;
      rx_tail_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        binary_q <= cfg_data_i;
      end
      if (commit) begin
        tx_head_q <= tx_head_d;
        tx_tail_q <= tx_tail_d;
        rx_head_q <= rx_head_d;
        rx_tail_q <= rx_tail_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      act_q  <= bufu_pkg::action_e'(s_axis_tuser);
      byte_q <= s_axis_tdata[7:0];
      free_q <= s_axis_tdata[8];
      err_q  <= s_axis_tdata[9];
    end else if (commit) begin
      free_q <= free_d;
    end
    if (commit) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b0, out_q.tx_count, out_q.rx_count, out_q.rx_byte,
                          out_q.rx_valid, out_q.tx_byte, out_q.tx_valid};
  assign m_axis_tuser  = out_q.status;
  assign m_axis_tlast  = out_q.last;

  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_accept |=> (state_q == ST_EXEC))
    else $error("accepted command did not enter execution");

  a_split_second: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (commit && (state_q == ST_EXEC) && lf_split) |=> (state_q == ST_EMIT2))
    else $error("line feed split lost its second result");

  a_one_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[9]))
    else $error("result carries both a tx and an rx byte");

  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser == bufu_pkg::STAT_RX_EMPTY)) |->
      (m_axis_tdata[21:18] == 4'd0))
    else $error("rx empty status with nonzero rx count");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready) |-> !commit)
    else $error("pending result overwritten");

endmodule

`default_nettype wire
